// ===== rtl/tdq_pkg.sv =====
package tdq_pkg;

  localparam int NumFields = 5;
  localparam int ValW = 32;
  localparam int ScaleW = 13;
  localparam int ThreshW = 16;
  localparam int SlotW = 8;
  localparam int DefSlots = 256;

  localparam logic [2:0] RegUseQuant = 3'd0;
  localparam logic [2:0] RegThresh = 3'd1;
  localparam logic [2:0] RegPosScale = 3'd2;
  localparam logic [2:0] RegRotScale = 3'd3;
  localparam logic [2:0] RegSizeScale = 3'd4;

  typedef logic signed [ValW-1:0] val_t;
  typedef val_t [NumFields-1:0] vals_t;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic force_full;
    vals_t vals;
  } item_t;

  typedef struct packed {
    logic skipped;
    logic [NumFields-1:0] mask;
    logic quant;
    vals_t vals;
  } result_t;

  function automatic logic signed [ValW-1:0] round_q16(input logic signed [45:0] p);
    logic [45:0] mag;
    logic [45:0] r;
    begin
      mag = p[45] ? 46'(-p) : 46'(p);
      r = (mag + 46'd32768) >> 16;
      round_q16 = p[45] ? ValW'(-r) : ValW'(r);
    end
  endfunction

endpackage

// ===== rtl/tdq_front.sv =====
// Front part: registers accepted items in a two-entry queue.
module tdq_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  tdq_pkg::item_t in_item,
  output logic q_valid,
  input  logic q_ready,
  output tdq_pkg::item_t q_item
);
  import tdq_pkg::*;

  item_t mem [2];
  logic wp;
  logic rp;
  logic [1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_item = mem[rp];
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_item;
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !pop) else $error("pop from empty queue");

endmodule

// ===== rtl/tdq_back.sv =====
// Back part: table read, compare, scale, write back, output register.
module tdq_back #(
  parameter int SLOTS = tdq_pkg::DefSlots
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  tdq_pkg::item_t q_item,
  input  logic use_quant,
  input  logic [tdq_pkg::ThreshW-1:0] thresh,
  input  logic [tdq_pkg::ScaleW-1:0] pos_scale,
  input  logic [tdq_pkg::ScaleW-1:0] rot_scale,
  input  logic [tdq_pkg::ScaleW-1:0] size_scale,
  output logic out_valid,
  input  logic out_ready,
  output tdq_pkg::result_t out_res
);
  import tdq_pkg::*;

  localparam int RowW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StCalc = 2'd2;

  vals_t table_mem [SLOTS];
  logic [SLOTS-1:0] valid_bits;
  logic [1:0] state;
  item_t cur;
  logic [RowW-1:0] row;
  vals_t old_vals;
  logic row_valid;
  logic signed [45:0] prod [NumFields];
  logic [NumFields-1:0] mask;
  logic [NumFields-1:0] fits;
  logic quant;
  result_t res;
  logic take;
  logic [RowW-1:0] row_lut [1 << SlotW];

  assign q_ready = (state == StIdle);
  assign take = q_valid && q_ready;

  // Slot to row mapping is a constant table, so any table size works.
  for (genvar g = 0; g < (1 << SlotW); g++) begin : g_row
    assign row_lut[g] = RowW'(g % SLOTS);
  end

  assign row = row_lut[cur.slot];

  always_comb begin
    logic signed [ValW:0] d;
    logic [ScaleW-1:0] sc;
    for (int i = 0; i < NumFields; i++) begin
      d = {old_vals[i][ValW-1], old_vals[i]} - {cur.vals[i][ValW-1], cur.vals[i]};
      if (d < 0) d = -d;
      mask[i] = cur.force_full || !row_valid || (d > $signed({17'd0, thresh}));
      sc = (i < 2) ? pos_scale : ((i == 2) ? rot_scale : size_scale);
      prod[i] = 46'(cur.vals[i]) * $signed({33'd0, sc});
      fits[i] = !mask[i] || (prod[i] >= -46'sd2147483648 && prod[i] <= 46'sd2147418112);
    end
    quant = use_quant && (&fits);
    res = '0;
    if (mask == '0) begin
      res.skipped = 1'b1;
    end else begin
      res.mask = mask;
      res.quant = quant;
      for (int i = 0; i < NumFields; i++) begin
        if (mask[i]) res.vals[i] = quant ? round_q16(prod[i]) : cur.vals[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) cur <= q_item;
    if (state == StRead) begin
      old_vals <= table_mem[row];
      row_valid <= valid_bits[row];
    end
    if (state == StCalc && !(out_valid && !out_ready) && mask != '0) begin
      table_mem[row] <= cur.vals;
    end
    if (state == StCalc && !(out_valid && !out_ready)) out_res <= res;
    if (rst) begin
      state <= StIdle;
      out_valid <= 1'b0;
      valid_bits <= '0;
    end else begin
      if (out_valid && out_ready && state != StCalc) out_valid <= 1'b0;
      unique case (state)
        StIdle: if (take) state <= StRead;
        StRead: state <= StCalc;
        StCalc: begin
          if (!(out_valid && !out_ready)) begin
            out_valid <= 1'b1;
            if (mask != '0) valid_bits[row] <= 1'b1;
            state <= StIdle;
          end
        end
        default: state <= StIdle;
      endcase
    end
  end

  a_skip_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.skipped |-> out_res.mask == '0 && !out_res.quant)
    else $error("skipped result carries data");
  a_mask_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.skipped |-> out_res.mask != '0)
    else $error("sent result has empty mask");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_res))
    else $error("result changed while stalled");

endmodule

// ===== rtl/transform_delta_quantizer.sv =====
// Transform delta quantizer.
// Slave stream s_axis_*: one entity update per transfer. Master stream
// m_axis_*: exactly one result per update, in order. Config channel
// cfg_valid/cfg_ready/cfg_index/cfg_data writes registers 0 to 4; others
// are ignored. Configuration is always ready.
// A two-entry queue takes updates; the back end handles one update at a
// time (accept, table read, compute and write back) and takes no new
// update before the last one is written back; it waits while the master
// is not ready for a held result. From an idle back end, the update is
// registered, its table row is read into a register, then the result is.
// A table read-modify-write completes before the next update is read, so
// updates to the same slot need no forwarding.
// Reset clears all slot valid bits at once and loads the default registers.
// When the receiver stalls the result holds, the back end waits, and the
// queue fills and then drops s_axis_tready.
module transform_delta_quantizer #(
  parameter int SLOTS = tdq_pkg::DefSlots
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // entity_slot[7:0], force_full[8], pos_x[40:9], pos_y[72:41], angle[104:73],
  // stretch_x[136:105], stretch_y[168:137], zero fill to 176 bits.
  input  logic [175:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // skipped[0], field_mask[5:1], is_quantized[6], out_x[38:7], out_y[70:39],
  // out_angle[102:71], out_stretch_x[134:103], out_stretch_y[166:135],
  // zero fill to 168 bits.
  output logic [167:0] m_axis_tdata,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);
  import tdq_pkg::*;

  item_t in_item;
  item_t q_item;
  logic q_valid;
  logic q_ready;
  result_t res;
  logic use_quant;
  logic [ThreshW-1:0] thresh;
  logic [ScaleW-1:0] pos_scale;
  logic [ScaleW-1:0] rot_scale;
  logic [ScaleW-1:0] size_scale;

  assign cfg_ready = 1'b1;
  assign in_item.slot = s_axis_tdata[7:0];
  assign in_item.force_full = s_axis_tdata[8];
  assign in_item.vals[0] = s_axis_tdata[40:9];
  assign in_item.vals[1] = s_axis_tdata[72:41];
  assign in_item.vals[2] = s_axis_tdata[104:73];
  assign in_item.vals[3] = s_axis_tdata[136:105];
  assign in_item.vals[4] = s_axis_tdata[168:137];

  assign m_axis_tdata = {1'b0, res.vals[4], res.vals[3], res.vals[2], res.vals[1],
                         res.vals[0], res.quant, res.mask, res.skipped};

  always_ff @(posedge clk) begin
    if (rst) begin
      use_quant <= 1'b1;
      thresh <= 16'd6;
      pos_scale <= 13'd10;
      rot_scale <= 13'd1000;
      size_scale <= 13'd100;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegUseQuant: use_quant <= cfg_data[0];
        RegThresh: thresh <= cfg_data;
        RegPosScale: pos_scale <= cfg_data[ScaleW-1:0];
        RegRotScale: rot_scale <= cfg_data[ScaleW-1:0];
        RegSizeScale: size_scale <= cfg_data[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  tdq_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
  );

  tdq_back #(.SLOTS(SLOTS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
    .use_quant(use_quant), .thresh(thresh), .pos_scale(pos_scale),
    .rot_scale(rot_scale), .size_scale(size_scale),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_res(res)
  );

endmodule
